// ===== rtl/core/mandelbrot_membership_test_core_defines.svh =====
// Assertion macros for the Mandelbrot membership test core.
// Used by the port checker; depends on nothing else.
`ifndef MANDELBROT_MEMBERSHIP_TEST_CORE_DEFINES_SVH
`define MANDELBROT_MEMBERSHIP_TEST_CORE_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define MBT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds while reset is asserted.
`define MBT_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/core/mbt_pkg.sv =====
// Shared widths, types and interface structs for the Mandelbrot test core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package mbt_pkg;

    // Coordinate format: signed, FRAC_BITS fraction bits
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;

    // Working values stay below 32 in magnitude: sign plus 5 integer bits
    localparam int WORK_W  = FRAC_BITS + 6;
    // Range checks on the raw point need at least +/-2 representable
    localparam int CMP_W   = (COORD_WIDTH > FRAC_BITS + 3) ? COORD_WIDTH : FRAC_BITS + 3;
    // Multiplier splits each magnitude into two halves
    localparam int HALF_W  = (WORK_W + 1) / 2;
    localparam int ACC_W   = 4 * HALF_W;
    localparam int ITER_W  = 16;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [CMP_W-1:0]       cmp_t;
    typedef logic signed [WORK_W-1:0]      work_t;
    typedef logic        [ITER_W-1:0]      iter_t;

    localparam iter_t MAX_ITER_RESET = iter_t'(256);

    typedef struct packed {
        logic  start;
        work_t a;
        work_t b;
    } mul_req_t;

    typedef struct packed {
        logic  done;
        work_t p;
    } mul_rsp_t;

    typedef struct packed {
        logic start;
        logic ack;
    } eng_cmd_t;

    typedef struct packed {
        logic done;
        logic in_set;
    } eng_rsp_t;

endpackage

// ===== rtl/core/mbt_mul.sv =====
// Shared fixed-point multiplier: four half-width partial products, one per cycle.
// Result is the exact product floored to FRAC_BITS fraction bits. Uses mbt_pkg.
`timescale 1ns / 1ps

module mbt_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  mbt_pkg::mul_req_t req,
    output mbt_pkg::mul_rsp_t rsp
);
    import mbt_pkg::*;

    typedef logic [2*HALF_W-1:0] mag_t;
    typedef logic [HALF_W-1:0]   part_t;
    typedef logic [ACC_W-1:0]    acc_t;

    localparam logic [2:0] STEP_PP_LAST = 3'd3;
    localparam logic [2:0] STEP_LAST    = 3'd5;

    logic              busy_reg, busy_next;
    logic [2:0]        step_reg, step_next;
    mag_t              a_mag_reg, a_mag_next;
    mag_t              b_mag_reg, b_mag_next;
    logic              neg_reg, neg_next;
    mag_t              pp_reg, pp_next;
    logic [1:0]        pp_idx_reg, pp_idx_next;
    logic              pp_vld_reg, pp_vld_next;
    acc_t              acc_reg, acc_next;
    logic              done_reg, done_next;
    work_t             p_reg, p_next;

    logic [WORK_W-1:0] a_abs, b_abs;
    part_t             a_part, b_part;
    acc_t              pp_shifted;
    acc_t              prod;

    always_comb
    begin
        a_abs = req.a[WORK_W-1] ? (~req.a + 1'b1) : req.a;
        b_abs = req.b[WORK_W-1] ? (~req.b + 1'b1) : req.b;

        a_part = step_reg[0] ? a_mag_reg[2*HALF_W-1:HALF_W] : a_mag_reg[HALF_W-1:0];
        b_part = step_reg[1] ? b_mag_reg[2*HALF_W-1:HALF_W] : b_mag_reg[HALF_W-1:0];

        unique case (pp_idx_reg)
            2'b00:        pp_shifted = acc_t'(pp_reg);
            2'b01, 2'b10: pp_shifted = acc_t'(pp_reg) << HALF_W;
            2'b11:        pp_shifted = acc_t'(pp_reg) << (2 * HALF_W);
            default:      pp_shifted = acc_t'(pp_reg);
        endcase

        // two's complement of the magnitude, then the floor is a plain bit-select
        prod = neg_reg ? (~acc_reg + 1'b1) : acc_reg;

        busy_next   = busy_reg;
        step_next   = step_reg;
        a_mag_next  = a_mag_reg;
        b_mag_next  = b_mag_reg;
        neg_next    = neg_reg;
        pp_next     = pp_reg;
        pp_idx_next = pp_idx_reg;
        pp_vld_next = 1'b0;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        p_next      = p_reg;

        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next  = 1'b1;
                step_next  = '0;
                a_mag_next = mag_t'(a_abs);
                b_mag_next = mag_t'(b_abs);
                neg_next   = req.a[WORK_W-1] ^ req.b[WORK_W-1];
                acc_next   = '0;
            end
        end
        else
        begin
            step_next = step_reg + 1'b1;
            if (step_reg <= STEP_PP_LAST)
            begin
                pp_next     = a_part * b_part;
                pp_idx_next = step_reg[1:0];
                pp_vld_next = 1'b1;
            end
            if (pp_vld_reg)
            begin
                acc_next = acc_reg + pp_shifted;
            end
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                p_next    = $signed(prod[FRAC_BITS +: WORK_W]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            pp_vld_reg <= pp_vld_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg  <= a_mag_next;
        b_mag_reg  <= b_mag_next;
        neg_reg    <= neg_next;
        pp_reg     <= pp_next;
        pp_idx_reg <= pp_idx_next;
        acc_reg    <= acc_next;
        p_reg      <= p_next;
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.p    = p_reg;
    end

endmodule

// ===== rtl/core/mbt_engine.sv =====
// Sequencer for the membership test: range checks, cardioid and bulb tests,
// then the z = z*z + c loop, all products through mbt_mul. Uses mbt_pkg.
`timescale 1ns / 1ps

module mbt_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  mbt_pkg::eng_cmd_t cmd,
    input  mbt_pkg::coord_t   c_real,
    input  mbt_pkg::coord_t   c_imag,
    input  mbt_pkg::iter_t    max_iter,
    output mbt_pkg::eng_rsp_t rsp,
    output mbt_pkg::mul_req_t mreq,
    input  mbt_pkg::mul_rsp_t mrsp
);
    import mbt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ITER = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_CARD = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [2:0] OP_Y2  = 3'd0;  // cy*cy
    localparam logic [2:0] OP_UU  = 3'd1;  // u*u
    localparam logic [2:0] OP_QQU = 3'd2;  // q*(q+u)
    localparam logic [2:0] OP_WW  = 3'd3;  // (cx+1)^2
    localparam logic [2:0] OP_PXY = 3'd4;  // zx*zy
    localparam logic [2:0] OP_NXX = 3'd5;  // new zx squared
    localparam logic [2:0] OP_NYY = 3'd6;  // new zy squared

    localparam cmp_t  C_ZERO      = '0;
    localparam cmp_t  C_ONE       = cmp_t'(1) << FRAC_BITS;
    localparam cmp_t  C_TWO       = cmp_t'(2) << FRAC_BITS;
    localparam cmp_t  C_HALF      = cmp_t'(1) << (FRAC_BITS - 1);
    localparam work_t W_ONE       = work_t'(1) << FRAC_BITS;
    localparam work_t W_TWO       = work_t'(2) << FRAC_BITS;
    localparam work_t W_FOUR      = work_t'(4) << FRAC_BITS;
    localparam work_t W_QUARTER   = work_t'(1) << (FRAC_BITS - 2);
    localparam work_t W_SIXTEENTH = work_t'(1) << (FRAC_BITS - 4);
    localparam work_t W_ZERO      = '0;

    logic [2:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic       mul_start_reg, mul_start_next;
    work_t      mul_a_reg, mul_a_next;
    work_t      mul_b_reg, mul_b_next;
    work_t      cx_reg, cx_next;
    work_t      cy_reg, cy_next;
    work_t      u_reg, u_next;
    work_t      y2_reg, y2_next;
    work_t      q_reg, q_next;
    work_t      sx_reg, sx_next;
    work_t      sy_reg, sy_next;
    work_t      pxy_reg, pxy_next;
    work_t      zx_reg, zx_next;
    work_t      zy_reg, zy_next;
    iter_t      n_reg, n_next;
    logic       card_reg, card_next;
    logic       bulb_reg, bulb_next;
    logic       in_set_reg, in_set_next;

    cmp_t       cx_c, cy_c;
    work_t      cx_w, cy_w;
    logic       far, card_box, bulb_box;
    work_t      nx, ny;
    logic       nz_far;

    always_comb
    begin
        cx_c = cmp_t'(c_real);
        cy_c = cmp_t'(c_imag);
        cx_w = work_t'(cx_c);
        cy_w = work_t'(cy_c);

        far      = (cx_c > C_TWO) || (cx_c < -C_TWO) || (cy_c > C_TWO) || (cy_c < -C_TWO);
        card_box = (cx_c >= -C_ONE) && (cx_c <= C_HALF) && (cy_c >= -C_ONE) && (cy_c <= C_ONE);
        bulb_box = (cx_c >= -C_TWO) && (cx_c <= C_ZERO) && (cy_c >= -C_ONE) && (cy_c <= C_ONE);

        nx     = sx_reg - sy_reg + cx_reg;
        ny     = (pxy_reg <<< 1) + cy_reg;
        nz_far = (nx > W_TWO) || (nx < -W_TWO) || (ny > W_TWO) || (ny < -W_TWO);

        state_next     = state_reg;
        op_next        = op_reg;
        mul_start_next = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        u_next         = u_reg;
        y2_next        = y2_reg;
        q_next         = q_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        pxy_next       = pxy_reg;
        zx_next        = zx_reg;
        zy_next        = zy_reg;
        n_next         = n_reg;
        card_next      = card_reg;
        bulb_next      = bulb_reg;
        in_set_next    = in_set_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    cx_next   = cx_w;
                    cy_next   = cy_w;
                    u_next    = cx_w - W_QUARTER;
                    card_next = card_box;
                    bulb_next = bulb_box;
                    if (far)
                    begin
                        in_set_next = (max_iter == '0);
                        state_next  = ST_DONE;
                    end
                    else if (card_box || bulb_box)
                    begin
                        mul_start_next = 1'b1;
                        mul_a_next     = cy_w;
                        mul_b_next     = cy_w;
                        op_next        = OP_Y2;
                        state_next     = ST_WAIT;
                    end
                    else
                    begin
                        zx_next    = W_ZERO;
                        zy_next    = W_ZERO;
                        sx_next    = W_ZERO;
                        sy_next    = W_ZERO;
                        n_next     = '0;
                        state_next = ST_ITER;
                    end
                end
            end

            ST_WAIT:
            begin
                if (mrsp.done)
                begin
                    unique case (op_reg)
                        OP_Y2:
                        begin
                            y2_next        = mrsp.p;
                            mul_start_next = 1'b1;
                            op_next        = card_reg ? OP_UU : OP_WW;
                            mul_a_next     = card_reg ? u_reg : (cx_reg + W_ONE);
                            mul_b_next     = card_reg ? u_reg : (cx_reg + W_ONE);
                        end
                        OP_UU:
                        begin
                            q_next     = mrsp.p + y2_reg;
                            state_next = ST_CARD;
                        end
                        OP_QQU:
                        begin
                            if (mrsp.p < (y2_reg >>> 2))
                            begin
                                in_set_next = 1'b1;
                                state_next  = ST_DONE;
                            end
                            else if (bulb_reg)
                            begin
                                mul_start_next = 1'b1;
                                mul_a_next     = cx_reg + W_ONE;
                                mul_b_next     = cx_reg + W_ONE;
                                op_next        = OP_WW;
                            end
                            else
                            begin
                                zx_next    = W_ZERO;
                                zy_next    = W_ZERO;
                                sx_next    = W_ZERO;
                                sy_next    = W_ZERO;
                                n_next     = '0;
                                state_next = ST_ITER;
                            end
                        end
                        OP_WW:
                        begin
                            if ((mrsp.p + y2_reg) < W_SIXTEENTH)
                            begin
                                in_set_next = 1'b1;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                zx_next    = W_ZERO;
                                zy_next    = W_ZERO;
                                sx_next    = W_ZERO;
                                sy_next    = W_ZERO;
                                n_next     = '0;
                                state_next = ST_ITER;
                            end
                        end
                        OP_PXY:
                        begin
                            pxy_next   = mrsp.p;
                            state_next = ST_STEP;
                        end
                        OP_NXX:
                        begin
                            sx_next        = mrsp.p;
                            mul_start_next = 1'b1;
                            mul_a_next     = zy_reg;
                            mul_b_next     = zy_reg;
                            op_next        = OP_NYY;
                        end
                        OP_NYY:
                        begin
                            sy_next = mrsp.p;
                            if ((sx_reg + mrsp.p) > W_FOUR)
                            begin
                                in_set_next = 1'b0;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                n_next     = n_reg + 1'b1;
                                state_next = ST_ITER;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CARD:
            begin
                mul_start_next = 1'b1;
                mul_a_next     = q_reg;
                mul_b_next     = q_reg + u_reg;
                op_next        = OP_QQU;
                state_next     = ST_WAIT;
            end

            ST_ITER:
            begin
                if (n_reg == max_iter)
                begin
                    in_set_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    mul_start_next = 1'b1;
                    mul_a_next     = zx_reg;
                    mul_b_next     = zy_reg;
                    op_next        = OP_PXY;
                    state_next     = ST_WAIT;
                end
            end

            ST_STEP:
            begin
                if (nz_far)
                begin
                    in_set_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    // squares of the new z also serve as next pass's zx^2, zy^2
                    zx_next        = nx;
                    zy_next        = ny;
                    mul_start_next = 1'b1;
                    mul_a_next     = nx;
                    mul_b_next     = nx;
                    op_next        = OP_NXX;
                    state_next     = ST_WAIT;
                end
            end

            ST_DONE:
            begin
                if (cmd.ack)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_Y2;
            mul_start_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            mul_start_reg <= mul_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        u_reg      <= u_next;
        y2_reg     <= y2_next;
        q_reg      <= q_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        pxy_reg    <= pxy_next;
        zx_reg     <= zx_next;
        zy_reg     <= zy_next;
        n_reg      <= n_next;
        card_reg   <= card_next;
        bulb_reg   <= bulb_next;
        in_set_reg <= in_set_next;
    end

    always_comb
    begin
        mreq.start = mul_start_reg;
        mreq.a     = mul_a_reg;
        mreq.b     = mul_b_reg;
        rsp.done   = (state_reg == ST_DONE);
        rsp.in_set = in_set_reg;
    end

endmodule

// ===== rtl/core/mandelbrot_membership_test_core.sv =====
// Result paths: a far-out point is answered by the range check alone; a cardioid or
//   bulb hit ends the test early, the bulb test also following a failed cardioid test;
//   otherwise the z loop runs until z escapes or max_iterations passes are done.
// Throughput: one point at a time, the next one taken once the result shows; set by
//   the shared multiplier (three products per iteration) and the loop-carried z.
// Reset: async active-low; max_iterations returns to 256, no result pending.
`timescale 1ns / 1ps

// Top level: point/result handshakes, max_iterations register, output register.
// Instantiates mbt_engine (sequencer) and mbt_mul (shared multiplier).
module mandelbrot_membership_test_core (
    input  logic                  clk,
    input  logic                  rst_n,
    // point channel
    input  logic                  pt_valid,
    output logic                  pt_stall,
    input  mbt_pkg::coord_t       c_real,
    input  mbt_pkg::coord_t       c_imag,
    // result channel
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  in_set,
    // configuration
    input  logic                  cfg_wr_en,
    input  mbt_pkg::iter_t        cfg_wr_data
);
    import mbt_pkg::*;

    iter_t     max_iter_reg, max_iter_next;
    logic      busy_reg, busy_next;
    logic      res_valid_reg, res_valid_next;
    logic      in_set_reg, in_set_next;

    logic      pt_accept;
    logic      res_take;
    eng_cmd_t  ecmd;
    eng_rsp_t  ersp;
    mul_req_t  mreq;
    mul_rsp_t  mrsp;

    // busy covers the whole point transaction until its result reaches the
    // output register; the output register lets the next point start while
    // the previous result still waits downstream.
    always_comb
    begin
        pt_accept = pt_valid && !busy_reg;
        res_take  = ersp.done && (!res_valid_reg || !res_stall);

        ecmd.start = pt_accept;
        ecmd.ack   = res_take;

        max_iter_next = cfg_wr_en ? cfg_wr_data : max_iter_reg;

        busy_next = busy_reg;
        if (pt_accept)
        begin
            busy_next = 1'b1;
        end
        else if (res_take)
        begin
            busy_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (res_take)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end

        in_set_next = res_take ? ersp.in_set : in_set_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg  <= MAX_ITER_RESET;
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            max_iter_reg  <= max_iter_next;
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_set_reg <= in_set_next;
    end

    // sequencer: range check, cardioid and bulb shortcuts, escape loop
    mbt_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (ecmd),
        .c_real   (c_real),
        .c_imag   (c_imag),
        .max_iter (max_iter_reg),
        .rsp      (ersp),
        .mreq     (mreq),
        .mrsp     (mrsp)
    );

    // the one multiplier every product goes through
    mbt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign pt_stall  = busy_reg;
    assign res_valid = res_valid_reg;
    assign in_set    = in_set_reg;

endmodule

// ===== rtl/core/mbt_checker.sv =====
// Port-level checker for the Mandelbrot test core, bound to the top level.
// Uses mbt_pkg and the assertion macros of the core's defines header.
`timescale 1ns / 1ps
`include "mandelbrot_membership_test_core_defines.svh"

module mbt_checker (
    input logic clk,
    input logic rst_n,
    input logic pt_valid,
    input logic pt_stall,
    input logic res_valid,
    input logic res_stall,
    input logic in_set
);
    import mbt_pkg::*;

    // no result shows once reset has been seen at an edge
    `MBT_ASSERT_RST(a_no_res_in_reset, clk, !rst_n |=> !res_valid, "result valid during reset")

    // a held result keeps its value
    `MBT_ASSERT(a_res_hold, clk, rst_n, res_valid && res_stall |=> res_valid && $stable(in_set), "stalled result changed")

    // an accepted point blocks the channel until its result is out
    `MBT_ASSERT(a_busy_after_accept, clk, rst_n, pt_valid && !pt_stall |=> pt_stall, "point channel open during work")

    // a new result frees the point channel
    `MBT_ASSERT(a_free_on_result, clk, rst_n, $rose(res_valid) |-> !pt_stall, "point channel stalled after result")

endmodule

bind mandelbrot_membership_test_core mbt_checker u_mbt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .in_set    (in_set)
);
